// File: src/ntc_pkg.sv
// shared types and constants for the thermistor average and convert block
`default_nettype none
package ntc_pkg;

    // converter input window
    localparam int SAMPLE_W = 11;
    localparam int AVG_W    = 10;
    localparam int ADC_MAX  = 1023;

    // configuration register indexes
    localparam logic [1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [1:0] REG_BETA       = 2'd1;
    localparam logic [1:0] REG_REF_TEMP   = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int FULL_W     = 13;
    localparam int BETA_W     = 14;
    localparam int REFT_W     = 9;
    localparam int TEMP_W     = 18;

    localparam logic [FULL_W-1:0] FULL_RESET = 13'd1023;
    localparam logic [BETA_W-1:0] BETA_RESET = 14'd3950;
    localparam logic [REFT_W-1:0] REFT_RESET = 9'd25;

    // fixed point constants
    localparam logic [47:0] LN2_Q48        = 48'hB17217F7D1CF;
    localparam int          ABS_ZERO_CENTI = 27315;
    localparam int          TEMP_MAX_CENTI = 100000;
    localparam int          TK_MAX         = 127315;
    localparam int          TERMS          = 16;

    // queue between front and back
    localparam int FIFO_DEPTH = 2;

    // shared divider
    localparam int DVD_W = 77;
    localparam int DSR_W = 60;
    localparam int QUO_W = 49;
    localparam int ITR_W = 7;
    localparam logic [QUO_W-1:0] Q_CAP = 49'h100_0000_0000;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
        logic [ITR_W-1:0] iters;
        logic             cap;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
        logic             sat;
    } div_stat_t;

endpackage
`default_nettype wire

// File: src/ntc_front.sv
// front end: sample filtering, accumulation and block average
`default_nettype none
module ntc_front #(
    parameter int NUM_SAMPLES = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ntc_pkg::SAMPLE_W-1:0]  s_sample,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output logic [ntc_pkg::AVG_W-1:0]          push_avg
);
    localparam int SUM_W = $clog2(ntc_pkg::ADC_MAX * NUM_SAMPLES + 1);
    localparam int CNT_W = $clog2(NUM_SAMPLES + 1);
    localparam int SH    = SUM_W + 7;
    localparam int RW    = SH + 1;
    localparam longint RECIP = ((64'd1 << SH) + NUM_SAMPLES - 1) / NUM_SAMPLES;

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                sample_ok, held_full, accept;
    logic [SUM_W+RW-1:0] scaled;

    // reciprocal multiply, exact for the sum range
    assign scaled    = sum_reg * RW'(RECIP);
    assign push_avg  = scaled[SH +: ntc_pkg::AVG_W];

    assign sample_ok = (s_sample != '0) && (s_sample <= ntc_pkg::SAMPLE_W'(ntc_pkg::ADC_MAX));
    assign held_full = (cnt_reg == CNT_W'(NUM_SAMPLES));
    assign s_ready   = !(held_full && !push_ready);
    assign accept    = s_valid && s_ready;
    assign push_valid = accept && sample_ok && held_full;

    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (accept && sample_ok) begin
            if (held_full) begin
                sum_next = '0;
                cnt_next = '0;
            end else begin
                sum_next = sum_reg + SUM_W'(s_sample);
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: src/ntc_fifo.sv
// short queue of averages between front and back
`default_nettype none
module ntc_fifo (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push_valid,
    output logic                              push_ready,
    input  wire logic [ntc_pkg::AVG_W-1:0]    push_avg,
    output logic                              q_valid,
    input  wire logic                         q_pop,
    output logic [ntc_pkg::AVG_W-1:0]         q_avg
);
    localparam int PTR_W = $clog2(ntc_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(ntc_pkg::FIFO_DEPTH + 1);

    logic [ntc_pkg::AVG_W-1:0] mem_reg [ntc_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(ntc_pkg::FIFO_DEPTH));
    assign q_valid    = (cnt_reg != '0);
    assign q_avg      = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = q_pop && q_valid;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_W'(ntc_pkg::FIFO_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_W'(ntc_pkg::FIFO_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_avg;
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: src/ntc_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module ntc_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ntc_pkg::div_req_t  req,
    output ntc_pkg::div_stat_t      stat
);
    logic                        busy_reg, done_reg, sat_reg, cap_reg;
    logic [ntc_pkg::ITR_W-1:0]   cnt_reg;
    logic [ntc_pkg::DVD_W-1:0]   dvd_reg;
    logic [ntc_pkg::DSR_W-1:0]   dsr_reg;
    logic [ntc_pkg::DSR_W:0]     rem_reg, rem_sh, rem_next;
    logic [ntc_pkg::QUO_W-1:0]   quo_reg, quo_sh;
    logic                        ge;

    assign rem_sh   = {rem_reg[ntc_pkg::DSR_W-1:0], dvd_reg[ntc_pkg::DVD_W-1]};
    assign ge       = (rem_sh >= {1'b0, dsr_reg});
    assign rem_next = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
    assign quo_sh   = {quo_reg[ntc_pkg::QUO_W-2:0], ge};

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;
    assign stat.sat      = sat_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            cnt_reg <= req.iters;
            cap_reg <= req.cap;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[ntc_pkg::DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - ntc_pkg::ITR_W'(1);
            if (!sat_reg) begin
                quo_reg <= quo_sh;
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                sat_reg  <= 1'b0;
            end else if (busy_reg) begin
                // quotient frozen once past the cap
                if (cap_reg && !sat_reg && (quo_sh > ntc_pkg::Q_CAP)) begin
                    sat_reg <= 1'b1;
                end
                if (cnt_reg == ntc_pkg::ITR_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: src/ntc_back.sv
// back end: logarithms, beta equation and result register
`default_nettype none
module ntc_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [ntc_pkg::FULL_W-1:0]          full_scale,
    input  wire logic [ntc_pkg::BETA_W-1:0]          beta,
    input  wire logic [ntc_pkg::REFT_W-1:0]          ref_temp,
    input  wire logic                                q_valid,
    input  wire logic [ntc_pkg::AVG_W-1:0]           q_avg,
    output logic                                     q_pop,
    output ntc_pkg::div_req_t                        div_req,
    input  wire ntc_pkg::div_stat_t                  div_stat,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ntc_pkg::AVG_W-1:0]                m_average_code,
    output logic signed [ntc_pkg::TEMP_W-1:0]        m_temp_centi_c,
    output logic                                     m_temp_valid
);
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_LNSET  = 10'b00_0000_0010,
        S_ZDIV   = 10'b00_0000_0100,
        S_MUL    = 10'b00_0000_1000,
        S_TSTART = 10'b00_0001_0000,
        S_TDIV   = 10'b00_0010_0000,
        S_LNEND  = 10'b00_0100_0000,
        S_DMUL   = 10'b00_1000_0000,
        S_DCHK   = 10'b01_0000_0000,
        S_QDIV   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [ntc_pkg::AVG_W-1:0]  avg_reg, avg_next;
    logic [12:0]                x_reg, x_next;
    logic [3:0]                 k_reg, k_next, k_w;
    logic                       second_reg, second_next;
    logic [3:0]                 j_reg, j_next;
    logic [47:0]                z2_reg, z2_next, term_reg, term_next;
    logic [48:0]                sum_reg, sum_next;
    logic [40:0]                ln1_reg, ln1_next, lnv;
    logic                       neg_reg, neg_next;
    logic [40:0]                lqa_reg, lqa_next;
    logic [2:0]                 mph_reg, mph_next;
    logic                       ret_reg, ret_next;
    logic [63:0]                prod_reg, prod_next;
    logic [57:0]                t_reg, t_next;
    logic [36:0]                num_reg, num_next;
    logic signed [59:0]         d_reg, d_next;

    logic                               out_valid_reg, out_valid_next;
    logic [ntc_pkg::AVG_W-1:0]          out_avg_reg, out_avg_next;
    logic signed [ntc_pkg::TEMP_W-1:0]  out_temp_reg, out_temp_next;
    logic                               out_tv_reg, out_tv_next;

    logic [31:0]        mop_a, mop_b;
    logic [47:0]        mul_b48, mres;
    logic signed [16:0] ref_ext, c_s;
    logic [15:0]        c_u;
    logic [20:0]        b100;
    logic [12:0]        pw;
    logic [52:0]        r_w;
    logic [41:0]        lq_diff;
    logic [48:0]        tk;

    // c = 100*T0 + 27315 stays positive over the whole 9 bit range
    assign ref_ext = {{8{ref_temp[ntc_pkg::REFT_W-1]}}, ref_temp};
    assign c_s     = ref_ext * 17'sd100 + 17'(ntc_pkg::ABS_ZERO_CENTI);
    assign c_u     = c_s[15:0];
    assign b100    = 21'(beta) * 21'd100;

    always_comb begin
        k_w = '0;
        for (int i = 0; i < 13; i++) begin
            if (x_reg[i]) begin
                k_w = 4'(i);
            end
        end
    end
    assign pw = 13'd1 << k_w;

    // log from k*ln2 + 2*atanh sum, rounded to Q36
    assign r_w     = 53'(k_reg) * 53'(ntc_pkg::LN2_Q48) + {3'b0, sum_reg, 1'b0};
    assign lnv     = 41'((r_w + 53'd2048) >> 12);
    assign lq_diff = {1'b0, ln1_reg} - {1'b0, lnv};

    assign mul_b48 = ret_reg ? z2_reg : term_reg;
    assign mres    = {prod_reg[31:0], 16'b0} + 48'(t_reg >> 16);

    assign tk = 49'((50'(div_stat.quotient) + 50'd1) >> 1);

    // shared 32x32 multiplier
    always_comb begin
        mop_a = '0;
        mop_b = '0;
        if (state_reg == S_MUL) begin
            case (mph_reg)
                3'd0: begin
                    mop_a = term_reg[31:0];
                    mop_b = mul_b48[31:0];
                end
                3'd1: begin
                    mop_a = {16'b0, term_reg[47:32]};
                    mop_b = mul_b48[31:0];
                end
                3'd2: begin
                    mop_a = term_reg[31:0];
                    mop_b = {16'b0, mul_b48[47:32]};
                end
                3'd3: begin
                    mop_a = {16'b0, term_reg[47:32]};
                    mop_b = {16'b0, mul_b48[47:32]};
                end
                default: ;
            endcase
        end else if (state_reg == S_DMUL) begin
            case (mph_reg)
                3'd0: begin
                    mop_a = {16'b0, c_u};
                    mop_b = lqa_reg[31:0];
                end
                3'd1: begin
                    mop_a = {16'b0, c_u};
                    mop_b = {23'b0, lqa_reg[40:32]};
                end
                3'd2: begin
                    mop_a = {16'b0, c_u};
                    mop_b = {11'b0, b100};
                end
                default: ;
            endcase
        end
    end
    assign prod_next = mop_a * mop_b;

    always_comb begin
        state_next     = state_reg;
        avg_next       = avg_reg;
        x_next         = x_reg;
        k_next         = k_reg;
        second_next    = second_reg;
        j_next         = j_reg;
        z2_next        = z2_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        ln1_next       = ln1_reg;
        neg_next       = neg_reg;
        lqa_next       = lqa_reg;
        mph_next       = mph_reg;
        ret_next       = ret_reg;
        t_next         = t_reg;
        num_next       = num_reg;
        d_next         = d_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_avg_next   = out_avg_reg;
        out_temp_next  = out_temp_reg;
        out_tv_next    = out_tv_reg;
        q_pop          = 1'b0;
        div_req        = '0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid && !out_valid_reg) begin
                    q_pop    = 1'b1;
                    avg_next = q_avg;
                    if ((q_avg == '0) || ({3'b0, q_avg} >= full_scale)) begin
                        out_valid_next = 1'b1;
                        out_avg_next   = q_avg;
                        out_temp_next  = '0;
                        out_tv_next    = 1'b0;
                    end else begin
                        x_next      = full_scale - {3'b0, q_avg};
                        second_next = 1'b0;
                        state_next  = S_LNSET;
                    end
                end
            end
            S_LNSET: begin
                k_next           = k_w;
                div_req.start    = 1'b1;
                div_req.dividend = {12'(x_reg - pw), 65'b0};
                div_req.divisor  = 60'(14'(x_reg) + 14'(pw));
                div_req.iters    = 7'd60;
                state_next       = S_ZDIV;
            end
            S_ZDIV: begin
                if (div_stat.done) begin
                    term_next  = div_stat.quotient[47:0];
                    mph_next   = '0;
                    ret_next   = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                mph_next = mph_reg + 3'd1;
                case (mph_reg)
                    3'd1: t_next = 58'(prod_reg[63:32]);
                    3'd2: t_next = t_reg + 58'(prod_reg);
                    3'd3: t_next = t_reg + 58'(prod_reg);
                    3'd4: begin
                        if (ret_reg) begin
                            term_next = mres;
                            j_next    = j_reg + 4'd1;
                        end else begin
                            z2_next  = mres;
                            j_next   = '0;
                            sum_next = '0;
                        end
                        state_next = S_TSTART;
                    end
                    default: ;
                endcase
            end
            S_TSTART: begin
                div_req.start    = 1'b1;
                div_req.dividend = {term_reg, 29'b0};
                div_req.divisor  = 60'({j_reg, 1'b1});
                div_req.iters    = 7'd48;
                state_next       = S_TDIV;
            end
            S_TDIV: begin
                if (div_stat.done) begin
                    sum_next = sum_reg + 49'(div_stat.quotient[47:0]);
                    if (j_reg == 4'(ntc_pkg::TERMS - 1)) begin
                        state_next = S_LNEND;
                    end else begin
                        mph_next   = '0;
                        ret_next   = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_LNEND: begin
                if (!second_reg) begin
                    ln1_next    = lnv;
                    second_next = 1'b1;
                    x_next      = {3'b0, avg_reg};
                    state_next  = S_LNSET;
                end else begin
                    neg_next   = lq_diff[41];
                    lqa_next   = lq_diff[41] ? 41'(-lq_diff) : lq_diff[40:0];
                    mph_next   = '0;
                    state_next = S_DMUL;
                end
            end
            S_DMUL: begin
                mph_next = mph_reg + 3'd1;
                case (mph_reg)
                    3'd1: t_next = 58'(prod_reg);
                    3'd2: t_next = t_reg + {prod_reg[25:0], 32'b0};
                    3'd3: begin
                        num_next   = prod_reg[36:0];
                        d_next     = signed'({3'b0, b100, 36'b0})
                                   + (neg_reg ? -signed'({2'b0, t_reg})
                                              : signed'({2'b0, t_reg}));
                        state_next = S_DCHK;
                    end
                    default: ;
                endcase
            end
            S_DCHK: begin
                if (d_reg <= 60'sd0) begin
                    out_valid_next = 1'b1;
                    out_avg_next   = avg_reg;
                    out_temp_next  = '0;
                    out_tv_next    = 1'b0;
                    state_next     = S_IDLE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {3'b0, num_reg, 37'b0};
                    div_req.divisor  = d_reg;
                    div_req.iters    = 7'd77;
                    div_req.cap      = 1'b1;
                    state_next       = S_QDIV;
                end
            end
            S_QDIV: begin
                if (div_stat.done) begin
                    out_valid_next = 1'b1;
                    out_avg_next   = avg_reg;
                    out_tv_next    = 1'b1;
                    if (div_stat.sat || (tk > 49'(ntc_pkg::TK_MAX))) begin
                        out_temp_next = 18'(ntc_pkg::TEMP_MAX_CENTI);
                    end else begin
                        out_temp_next = signed'(tk[17:0]) - 18'sd27315;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid        = out_valid_reg;
    assign m_average_code = out_avg_reg;
    assign m_temp_centi_c = out_temp_reg;
    assign m_temp_valid   = out_tv_reg;

    always_ff @(posedge aclk) begin
        avg_reg      <= avg_next;
        x_reg        <= x_next;
        k_reg        <= k_next;
        second_reg   <= second_next;
        j_reg        <= j_next;
        z2_reg       <= z2_next;
        term_reg     <= term_next;
        sum_reg      <= sum_next;
        ln1_reg      <= ln1_next;
        neg_reg      <= neg_next;
        lqa_reg      <= lqa_next;
        ret_reg      <= ret_next;
        prod_reg     <= prod_next;
        t_reg        <= t_next;
        num_reg      <= num_next;
        d_reg        <= d_next;
        out_avg_reg  <= out_avg_next;
        out_temp_reg <= out_temp_next;
        out_tv_reg   <= out_tv_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mph_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mph_reg       <= mph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_out_free_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result register occupied during conversion");

    a_invalid_temp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_temp_valid) |-> (m_temp_centi_c == '0))
        else $error("invalid result with non-zero temperature");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == S_IDLE) && q_valid && !out_valid_reg)
        else $error("queue popped outside idle");

endmodule
`default_nettype wire

// File: src/ntc_thermistor_average_convert.sv
// top level: sample averaging and beta-equation temperature conversion
// samples: one request per cycle unless a full block meets a full queue; the next in-range
//   request after NUM_SAMPLES held ones queues an average; conversion: one average at a time,
//   in the shared bit-serial divider (two logarithms of 16 terms each, then a 77 step quotient)
// a two-entry queue sits between front and back; results leave through an output register
// reset (aresetn, synchronous, active low) clears sum, count, queue, sequencer and registers
`default_nettype none
module ntc_thermistor_average_convert #(
    parameter int NUM_SAMPLES = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // sample requests
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [ntc_pkg::SAMPLE_W-1:0]          s_sample,
    // result requests
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [ntc_pkg::AVG_W-1:0]                  m_average_code,
    output logic signed [ntc_pkg::TEMP_W-1:0]          m_temp_centi_c,
    output logic                                       m_temp_valid,
    // configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ntc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [ntc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    // configuration registers
    logic [ntc_pkg::FULL_W-1:0] full_reg;
    logic [ntc_pkg::BETA_W-1:0] beta_reg;
    logic [ntc_pkg::REFT_W-1:0] reft_reg;

    // front to queue
    logic                       push_valid, push_ready;
    logic [ntc_pkg::AVG_W-1:0]  push_avg;

    // queue to back
    logic                       q_valid, q_pop;
    logic [ntc_pkg::AVG_W-1:0]  q_avg;

    // back to divider
    ntc_pkg::div_req_t          div_req;
    ntc_pkg::div_stat_t         div_stat;

    // writes always taken; the user must issue them only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= ntc_pkg::FULL_RESET;
            beta_reg <= ntc_pkg::BETA_RESET;
            reft_reg <= ntc_pkg::REFT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ntc_pkg::REG_FULL_SCALE: full_reg <= cfg_data[ntc_pkg::FULL_W-1:0];
                ntc_pkg::REG_BETA:       beta_reg <= cfg_data[ntc_pkg::BETA_W-1:0];
                ntc_pkg::REG_REF_TEMP:   reft_reg <= cfg_data[ntc_pkg::REFT_W-1:0];
                default: ;
            endcase
        end
    end

    // filter and accumulate
    ntc_front #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_avg   (push_avg)
    );

    // decoupling queue
    ntc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_avg   (push_avg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_avg      (q_avg)
    );

    // shared divider for z, series terms and final quotient
    ntc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat)
    );

    // conversion sequencer and result register
    ntc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .full_scale     (full_reg),
        .beta           (beta_reg),
        .ref_temp       (reft_reg),
        .q_valid        (q_valid),
        .q_avg          (q_avg),
        .q_pop          (q_pop),
        .div_req        (div_req),
        .div_stat       (div_stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average_code (m_average_code),
        .m_temp_centi_c (m_temp_centi_c),
        .m_temp_valid   (m_temp_valid)
    );

endmodule
`default_nettype wire

// File: dv/ntc_thermistor_average_convert_tb.sv
// testbench for the thermistor average and beta-equation temperature block
`timescale 1ns / 1ps
`default_nettype none
module ntc_thermistor_average_convert_tb;

    localparam int NUM_SAMPLES = 16;
    // own copies of the fixed point constants
    localparam logic [63:0] LN2_FRAC48 = 64'hB17217F7D1CF;
    localparam int          KELVIN_OFS = 27315;
    localparam int          HOT_LIMIT  = 100000;
    // index with no register behind it
    localparam logic [ntc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [ntc_pkg::AVG_W-1:0]  average_code;
        logic [ntc_pkg::TEMP_W-1:0] temp_centi_c;
        logic                       temp_valid;
    } reading_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ntc_pkg::SAMPLE_W-1:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ntc_pkg::AVG_W-1:0] m_average_code;
    logic signed [ntc_pkg::TEMP_W-1:0] m_temp_centi_c;
    logic m_temp_valid;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ntc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ntc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    ntc_thermistor_average_convert #(.NUM_SAMPLES(NUM_SAMPLES)) i_dut (.*);

    // predictor copy of registers and accumulator
    logic [ntc_pkg::FULL_W-1:0] full_scale;
    logic [ntc_pkg::BETA_W-1:0] beta;
    logic [ntc_pkg::REFT_W-1:0] ref_temp;
    int unsigned held_sum;
    int unsigned held_count;

    logic [ntc_pkg::SAMPLE_W-1:0] pending_samples[$];
    reading_t expected_readings[$];
    int directed_codes[8] = '{0, 2047, 1024, 1, 1023, 512, 0, 1536};
    int mismatches = 0;
    int readings_seen = 0;
    int undefined_seen = 0;
    int hot_clamped = 0;
    bit no_idle = 1'b0;
    int send_gap = 0;
    int sink_stall = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // (a*b) >> 48 with 64 bit wrap, both operands below 2^48
    function automatic logic [63:0] mul_frac48(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        t = ((a[31:0] * b[31:0]) >> 32) + (a >> 32) * b[31:0] + a[31:0] * (b >> 32);
        return (((a >> 32) * (b >> 32)) << 16) + (t >> 16);
    endfunction

    // natural log in Q36, rounded half up, via k*ln2 + 2*atanh series
    function automatic logic [63:0] log_q36(int unsigned x);
        int unsigned k;
        logic [63:0] pw, z, z2, term, acc, r;
        k = 0;
        acc = '0;
        while (k < 13 && (x >> (k + 1)) != 0) k++;
        pw = 64'd1 << k;
        z = ((64'(x) - pw) << 48) / (64'(x) + pw);
        z2 = mul_frac48(z, z);
        term = z;
        for (int j = 0; j < 16; j++) begin
            acc += term / 64'(2 * j + 1);
            term = mul_frac48(term, z2);
        end
        r = 64'(k) * LN2_FRAC48 + 2 * acc;
        return (r + (64'd1 << 11)) >> 12;
    endfunction

    // average and beta-equation temperature for one held block
    function automatic reading_t convert_block(int unsigned avg);
        reading_t rd;
        longint signed t0, c, lq, d;
        logic [63:0] num, ud, rem, q, tk, bitv;
        bit sat;
        rd.average_code = avg[ntc_pkg::AVG_W-1:0];
        rd.temp_centi_c = '0;
        rd.temp_valid = 1'b0;
        if (avg == 0 || avg >= full_scale) return rd;
        t0 = longint'($signed(ref_temp));
        c = 100 * t0 + KELVIN_OFS;
        lq = $signed(log_q36(full_scale - avg)) - $signed(log_q36(avg));
        d = $signed((64'(beta) * 100) << 36) + c * lq;
        if (d <= 0) return rd;
        ud = d;
        num = 64'd100 * 64'(c) * 64'(beta);
        rem = '0;
        q = '0;
        sat = 1'b0;
        for (int i = 76; i >= 0; i--) begin
            bitv = (i >= 37) ? ((num >> (i - 37)) & 64'd1) : 64'd0;
            rem = (rem << 1) | bitv;
            if (rem >= ud) begin
                rem -= ud;
                bitv = 64'd1;
            end else begin
                bitv = 64'd0;
            end
            if (!sat) begin
                q = (q << 1) | bitv;
                if (q > (64'd1 << 40)) sat = 1'b1;
            end
        end
        tk = (q + 1) >> 1;
        if (sat || tk > 64'(HOT_LIMIT + KELVIN_OFS))
            rd.temp_centi_c = ntc_pkg::TEMP_W'(HOT_LIMIT);
        else
            rd.temp_centi_c = ntc_pkg::TEMP_W'(longint'(tk) - KELVIN_OFS);
        rd.temp_valid = 1'b1;
        return rd;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    // sample driver: pops the pending queue, random gap after each request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold the request until taken
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
            s_valid <= 1'b1;
            s_sample <= pending_samples.pop_front();
            send_gap <= no_idle ? 0 : $urandom_range(0, 3);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result sink: random stall drawn after each taken result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            sink_stall <= no_idle ? 0 : $urandom_range(0, 3);
            m_ready <= no_idle;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // predictor: tracks register writes and accepted samples
    always @(posedge aclk) begin
        if (!aresetn) begin
            full_scale <= ntc_pkg::FULL_RESET;
            beta <= ntc_pkg::BETA_RESET;
            ref_temp <= ntc_pkg::REFT_RESET;
            held_sum = 0;
            held_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ntc_pkg::REG_FULL_SCALE: full_scale <= cfg_data[ntc_pkg::FULL_W-1:0];
                    ntc_pkg::REG_BETA:       beta <= cfg_data[ntc_pkg::BETA_W-1:0];
                    ntc_pkg::REG_REF_TEMP:   ref_temp <= cfg_data[ntc_pkg::REFT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready && s_sample != 0 && s_sample <= ntc_pkg::ADC_MAX) begin
                if (held_count >= NUM_SAMPLES) begin
                    expected_readings.push_back(convert_block(held_sum / NUM_SAMPLES));
                    held_sum = 0;
                    held_count = 0;
                end else begin
                    held_sum += 32'(s_sample);
                    held_count++;
                end
            end
        end
    end

    // monitor: compare each taken result with the oldest expectation
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            readings_seen++;
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected result, average", m_average_code, -1);
            end else begin
                want = expected_readings.pop_front();
                if (!want.temp_valid) undefined_seen++;
                if (want.temp_valid && $signed(want.temp_centi_c) == HOT_LIMIT) hot_clamped++;
                if (m_average_code != want.average_code)
                    report_mismatch("average_code", m_average_code, want.average_code);
                if (m_temp_centi_c != $signed(want.temp_centi_c))
                    report_mismatch("temp_centi_c", m_temp_centi_c,
                                    $signed(want.temp_centi_c));
                if (m_temp_valid != want.temp_valid)
                    report_mismatch("temp_valid", m_temp_valid, want.temp_valid);
            end
        end
    end

    task automatic write_reg(logic [ntc_pkg::CFG_IDX_W-1:0] idx,
                             logic [ntc_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // all requests sent and every result back, then let a conversion finish
    task automatic drain();
        while (pending_samples.size() > 0 || s_valid || expected_readings.size() > 0)
            @(posedge aclk);
        repeat (2500) @(posedge aclk);
    endtask

    task automatic push_block(int unsigned centre, int unsigned spread, int count);
        int v;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                pending_samples.push_back(ntc_pkg::SAMPLE_W'($urandom_range(0, 2047)));
            end else begin
                v = int'(centre) + $urandom_range(0, 2 * spread) - int'(spread);
                if (v < 1) v = 1;
                if (v > ntc_pkg::ADC_MAX) v = ntc_pkg::ADC_MAX;
                pending_samples.push_back(ntc_pkg::SAMPLE_W'(v));
            end
        end
    endtask

    int sent_items = 0;
    int n;

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset registers, field extremes and dropped codes
        no_idle = 1'b1;
        foreach (directed_codes[i])
            pending_samples.push_back(ntc_pkg::SAMPLE_W'(directed_codes[i]));
        // block near full scale
        repeat (10) pending_samples.push_back(ntc_pkg::SAMPLE_W'(1023));
        repeat (7) pending_samples.push_back(ntc_pkg::SAMPLE_W'(300));
        sent_items += 25;
        drain();

        // extremes: smallest full scale makes every average undefined
        write_reg(ntc_pkg::REG_FULL_SCALE, 14'd1);
        write_reg(ntc_pkg::REG_BETA, 14'd1);
        write_reg(ntc_pkg::REG_REF_TEMP, 14'h1CE);  // -50 C
        push_block(500, 400, 40);
        sent_items += 40;
        drain();
        // tiny beta, full scale 4096: both blocks average below half scale, so the denominator stays positive
        write_reg(ntc_pkg::REG_FULL_SCALE, 14'd4096);
        push_block(1000, 20, 40);
        push_block(20, 10, 40);
        sent_items += 80;
        drain();
        // beta zero and the top of every register
        write_reg(ntc_pkg::REG_BETA, 14'd0);
        write_reg(ntc_pkg::REG_REF_TEMP, 14'd150);
        push_block(700, 300, 40);
        sent_items += 40;
        drain();
        write_reg(ntc_pkg::REG_FULL_SCALE, 14'h3FFF);
        write_reg(ntc_pkg::REG_BETA, 14'h3FFF);
        write_reg(ntc_pkg::REG_REF_TEMP, 14'h3FFF);
        write_reg(REG_UNUSED, 14'h2AAA);  // unmapped index, no effect
        push_block(512, 500, 40);
        sent_items += 40;
        drain();
        write_reg(ntc_pkg::REG_BETA, 14'd10000);
        write_reg(ntc_pkg::REG_FULL_SCALE, 14'd1023);
        write_reg(ntc_pkg::REG_REF_TEMP, 14'd25);
        push_block(1000, 25, 40);
        sent_items += 40;
        drain();

        // random phases
        while (sent_items < 700) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
                write_reg(ntc_pkg::REG_FULL_SCALE,
                          ntc_pkg::CFG_DATA_W'($urandom_range(1, 1100)));
            if ($urandom_range(0, 1))
                write_reg(ntc_pkg::REG_BETA, ntc_pkg::CFG_DATA_W'($urandom_range(0, 10000)));
            if ($urandom_range(0, 1))
                write_reg(ntc_pkg::REG_REF_TEMP, ntc_pkg::CFG_DATA_W'($urandom_range(0, 511)));
            n = $urandom_range(40, 90);
            push_block($urandom_range(1, 1023), $urandom_range(0, 60), n);
            sent_items += n;
            drain();
        end

        $display("%0d samples sent over several register settings, %0d results checked",
                 sent_items, readings_seen);
        $display("%0d results undefined, %0d clamped hot", undefined_seen, hot_clamped);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("timeout after %0d results", readings_seen);
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
